// ----- design/isl_pkg.sv -----
package isl_pkg;

   localparam int DEPTH  = 64;
   localparam int DATA_W = 32;
   localparam int POS_W  = 7;
   localparam int CNT_W  = 7;

   // operation codes
   localparam logic [1:0] OP_APPEND = 2'd0;
   localparam logic [1:0] OP_INSERT = 2'd1;
   localparam logic [1:0] OP_REMOVE = 2'd2;
   localparam logic [1:0] OP_READ   = 2'd3;

   // status codes
   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_OOB  = 2'd1;
   localparam logic [1:0] ST_FULL = 2'd2;

   // command broadcast to every cell of the row
   typedef struct packed {
      logic              ins;
      logic              rem;
      logic [POS_W-1:0]  pos;
      logic [DATA_W-1:0] value;
   } cell_cmd_type;

endpackage

// ----- design/isl_cell.sv -----
module isl_cell (
   input  logic                        clock,
   input  isl_pkg::cell_cmd_type       cmd,
   input  logic [isl_pkg::POS_W-1:0]   idx,
   input  logic [isl_pkg::DATA_W-1:0]  prev_data,
   input  logic [isl_pkg::DATA_W-1:0]  next_data,
   input  logic [isl_pkg::POS_W-1:0]   rd_pos,
   output logic [isl_pkg::DATA_W-1:0]  data,
   output logic [isl_pkg::DATA_W-1:0]  rd_data
);
   import isl_pkg::*;

   logic [DATA_W-1:0] data_ff;
   logic [DATA_W-1:0] data_in;

   // insert: cells above pos take the lower neighbor, pos takes the new word
   // remove: cells at and above pos take the upper neighbor
   always_comb begin
      data_in = data_ff;
      if (cmd.ins) begin
         if (idx > cmd.pos) begin
            data_in = prev_data;
         end else if (idx == cmd.pos) begin
            data_in = cmd.value;
         end
      end else if (cmd.rem) begin
         if (idx >= cmd.pos) begin
            data_in = next_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data    = data_ff;
   assign rd_data = (idx == rd_pos) ? data_ff : '0;

endmodule

// ----- design/indexed_shift_list.sv -----
// indexed_shift_list: an ordered list of up to DEPTH (64) signed 32-bit words held
// in a row of identical cells, plus a live count. Each request appends, inserts at a
// position (later entries move up), removes at a position (later entries move down)
// or reads one entry; every request gives exactly one response with a status (ok,
// out of bounds, full), the count after the request and the word read (zero unless
// a read succeeds). All cells shift together, so a request is done in the cycle after
// it is accepted and a new request can be taken in every cycle; the
// response sits in an output register, and req_stall rises only while that register
// holds a response that the downstream side has not yet taken. Entries at or above
// the count hold stale data and are never returned. No clearing pass after reset.
module indexed_shift_list (
   input  logic                               clock,
   input  logic                               reset,
   // request channel
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [1:0]                         req_op,
   input  logic [isl_pkg::POS_W-1:0]          req_position,
   input  logic signed [isl_pkg::DATA_W-1:0]  req_value,
   // response channel
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [1:0]                         rsp_status,
   output logic [isl_pkg::CNT_W-1:0]          rsp_count,
   output logic signed [isl_pkg::DATA_W-1:0]  rsp_read_value
);
   import isl_pkg::*;

   // live count and response register
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [1:0]        rsp_status_ff, rsp_status_in;
   logic [CNT_W-1:0]  rsp_count_ff;
   logic [DATA_W-1:0] rsp_read_value_ff, rsp_read_value_in;

   logic              accept;
   logic              full;
   cell_cmd_type      cmd;

   // row of cells
   logic [DATA_W-1:0] cell_data [DEPTH];
   logic [DATA_W-1:0] cell_rd   [DEPTH];
   logic [DATA_W-1:0] rd_or;

   // hold off only while a finished response waits downstream
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;
   assign full      = (count_ff >= CNT_W'(DEPTH));

   // decode the request into a status and a cell command
   always_comb begin
      cmd               = '0;
      cmd.value         = req_value;
      rsp_status_in     = ST_OK;
      rsp_read_value_in = '0;
      count_in          = count_ff;
      case (req_op)
         OP_APPEND: begin
            // append is an insert at the current count
            if (full) begin
               rsp_status_in = ST_FULL;
            end else begin
               cmd.ins  = accept;
               cmd.pos  = POS_W'(count_ff);
               count_in = count_ff + CNT_W'(1);
            end
         end
         OP_INSERT: begin
            // out of bounds wins over full
            if (req_position > POS_W'(count_ff)) begin
               rsp_status_in = ST_OOB;
            end else if (full) begin
               rsp_status_in = ST_FULL;
            end else begin
               cmd.ins  = accept;
               cmd.pos  = req_position;
               count_in = count_ff + CNT_W'(1);
            end
         end
         OP_REMOVE: begin
            if (req_position >= POS_W'(count_ff)) begin
               rsp_status_in = ST_OOB;
            end else begin
               cmd.rem  = accept;
               cmd.pos  = req_position;
               count_in = count_ff - CNT_W'(1);
            end
         end
         OP_READ: begin
            if (req_position >= POS_W'(count_ff)) begin
               rsp_status_in = ST_OOB;
            end else begin
               rsp_read_value_in = rd_or;
            end
         end
         default: begin
            rsp_status_in = ST_OK;
         end
      endcase
   end

   // each cell sees its neighbors; the ends are tied to zero
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [DATA_W-1:0] prev_d;
      logic [DATA_W-1:0] next_d;
      if (i == 0) begin : g_first
         assign prev_d = '0;
      end else begin : g_mid_lo
         assign prev_d = cell_data[i-1];
      end
      if (i == DEPTH-1) begin : g_last
         assign next_d = '0;
      end else begin : g_mid_hi
         assign next_d = cell_data[i+1];
      end
      isl_cell u_cell (
         .clock     (clock),
         .cmd       (cmd),
         .idx       (POS_W'(i)),
         .prev_data (prev_d),
         .next_data (next_d),
         .rd_pos    (req_position),
         .data      (cell_data[i]),
         .rd_data   (cell_rd[i])
      );
   end

   // only the addressed cell drives a nonzero word, so an or combines them
   always_comb begin
      rd_or = '0;
      for (int i = 0; i < DEPTH; i++) begin
         rd_or = rd_or | cell_rd[i];
      end
   end

   assign rsp_valid_in = accept | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            count_ff <= count_in;
         end
      end
   end

   // response payload loads on each accepted request
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_status_ff     <= rsp_status_in;
         rsp_count_ff      <= count_in;
         rsp_read_value_ff <= rsp_read_value_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_count      = rsp_count_ff;
   assign rsp_read_value = $signed(rsp_read_value_ff);

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("count beyond depth");

   a_count_hold: assert property (@(posedge clock) disable iff (reset)
      !accept |=> $stable(count_ff))
      else $error("count moved without a request");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      accept |=> (count_ff == $past(count_ff) || count_ff == $past(count_ff) + CNT_W'(1)
                  || count_ff == $past(count_ff) - CNT_W'(1)))
      else $error("count moved by more than one");

   a_read_keeps_count: assert property (@(posedge clock) disable iff (reset)
      accept && req_op == OP_READ |=> $stable(count_ff))
      else $error("read changed the count");

   a_rd_only_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_read_value_ff != '0 |-> rsp_status_ff == ST_OK)
      else $error("read data on a failed request");
`endif

endmodule

// ----- sim/indexed_shift_list_tb.sv -----
`timescale 1ns / 100ps

module indexed_shift_list_tb;
   import isl_pkg::*;

   localparam int RANDOM_ITEMS = 800;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 10;

   // one request as it travels on the input channel
   typedef struct packed {
      logic [1:0]               op;
      logic [POS_W-1:0]         position;
      logic signed [DATA_W-1:0] value;
   } list_req_type;

   // one response as the block reports it
   typedef struct packed {
      logic [1:0]               status;
      logic [CNT_W-1:0]         count;
      logic signed [DATA_W-1:0] read_value;
   } list_rsp_type;

   // shape of the random stream: fill up, sit at full, drain, then mixed traffic
   typedef enum {PH_GROW, PH_AT_FULL, PH_SHRINK, PH_MIXED} traffic_phase_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                      req_valid    = 1'b0;
   logic [1:0]                req_op       = OP_APPEND;
   logic [POS_W-1:0]          req_position = '0;
   logic signed [DATA_W-1:0]  req_value    = '0;
   logic                      rsp_stall    = 1'b0;
   wire                       req_stall;
   wire                       rsp_valid;
   wire [1:0]                 rsp_status;
   wire [CNT_W-1:0]           rsp_count;
   wire signed [DATA_W-1:0]   rsp_read_value;

   // requests waiting for the driver, responses waiting for the block
   list_req_type req_q[$];
   list_rsp_type expected_rsp_q[$];

   // shadow of the list, updated once per accepted request
   logic signed [DATA_W-1:0] list_words[DEPTH];
   int                       list_len = 0;

   // length the generator assumes while building the stream
   int gen_len = 0;

   int  cycle_cnt     = 0;
   int  accepted_cnt  = 0;
   int  total_items   = 0;
   int  fail_cnt      = 0;
   int  req_gap_left  = 0;
   int  rsp_gap_left  = 0;
   logic req_accepted = 1'b0;
   logic hold_off     = 1'b0;

   indexed_shift_list DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_op         (req_op),
      .req_position   (req_position),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_count      (rsp_count),
      .rsp_read_value (rsp_read_value)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
   end

   // apply one request to the shadow list and return the response it should give
   function automatic list_rsp_type apply_list_op(list_req_type r);
      list_rsp_type rsp;
      rsp.status     = ST_OK;
      rsp.read_value = '0;
      case (r.op)
         OP_APPEND: begin
            if (list_len >= DEPTH) begin
               rsp.status = ST_FULL;
            end else begin
               list_words[list_len] = r.value;
               list_len++;
            end
         end
         OP_INSERT: begin
            // bounds check wins over the full check
            if (int'(r.position) > list_len) begin
               rsp.status = ST_OOB;
            end else if (list_len >= DEPTH) begin
               rsp.status = ST_FULL;
            end else begin
               for (int i = list_len; i > int'(r.position); i--)
                  list_words[i] = list_words[i-1];
               list_words[r.position] = r.value;
               list_len++;
            end
         end
         OP_REMOVE: begin
            if (int'(r.position) >= list_len) begin
               rsp.status = ST_OOB;
            end else begin
               for (int i = int'(r.position); i + 1 < list_len; i++)
                  list_words[i] = list_words[i+1];
               list_len--;
            end
         end
         default: begin
            if (int'(r.position) >= list_len)
               rsp.status = ST_OOB;
            else
               rsp.read_value = list_words[r.position];
         end
      endcase
      rsp.count = CNT_W'(list_len);
      return rsp;
   endfunction

   // queue a request and track the length it leaves behind
   task automatic push_req(logic [1:0] op, int pos, logic signed [DATA_W-1:0] val);
      list_req_type item;
      item.op       = op;
      item.position = POS_W'(pos);
      item.value    = val;
      req_q.push_back(item);
      case (op)
         OP_APPEND: if (gen_len < DEPTH) gen_len++;
         OP_INSERT: if (pos <= gen_len && gen_len < DEPTH) gen_len++;
         OP_REMOVE: if (pos < gen_len) gen_len--;
         default: ;
      endcase
   endtask

   // idle length: mostly short, a few long, none during calm stretches
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if ((cycle_cnt / 256) % 5 == 4) return 0;
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 10);
      return $urandom_range(11, 40);
   endfunction

   function automatic logic [1:0] pick_op(traffic_phase_type ph);
      int r;
      r = $urandom_range(0, 99);
      case (ph)
         PH_GROW: begin
            if (r < 45) return OP_APPEND;
            if (r < 80) return OP_INSERT;
            if (r < 88) return OP_REMOVE;
            return OP_READ;
         end
         PH_SHRINK: begin
            if (r < 8) return OP_APPEND;
            if (r < 16) return OP_INSERT;
            if (r < 70) return OP_REMOVE;
            return OP_READ;
         end
         default: begin
            if (r < 25) return OP_APPEND;
            if (r < 50) return OP_INSERT;
            if (r < 75) return OP_REMOVE;
            return OP_READ;
         end
      endcase
   endfunction

   // mostly in-range positions, with the end of the list and wild values mixed in
   function automatic int pick_position(logic [1:0] op);
      int r;
      int top;
      r   = $urandom_range(0, 99);
      top = (op == OP_INSERT) ? gen_len : gen_len - 1;
      if (r < 8) return $urandom_range(0, (1 << POS_W) - 1);
      if (r < 18) return gen_len;
      if (r < 26 || top < 0) return 0;
      return $urandom_range(0, top);
   endfunction

   function automatic logic signed [DATA_W-1:0] pick_value();
      case ($urandom_range(0, 19))
         0:       return {1'b1, {(DATA_W-1){1'b0}}};
         1:       return {1'b0, {(DATA_W-1){1'b1}}};
         2:       return '0;
         3:       return '1;
         default: return $urandom;
      endcase
   endfunction

   // stimulus and end of run
   initial begin : main_flow
      traffic_phase_type phase;
      int                phase_left;
      logic [1:0]        op;

      // empty list: every positional request is out of bounds
      push_req(OP_READ,   0, 32'sh1234_5678);
      push_req(OP_REMOVE, 0, '0);
      push_req(OP_INSERT, 1, 32'sh1111_1111);
      // build a short list through every insert flavor
      push_req(OP_INSERT, 0, {1'b1, {(DATA_W-1){1'b0}}});
      push_req(OP_APPEND, 127, {1'b0, {(DATA_W-1){1'b1}}});
      push_req(OP_INSERT, gen_len, '1);
      push_req(OP_INSERT, 0, '0);
      push_req(OP_INSERT, 2, 32'sh5a5a_5a5a);
      // reads at both ends and just past them, value ignored
      push_req(OP_READ, 0, 32'sh7eed_beef);
      push_req(OP_READ, gen_len - 1, '0);
      push_req(OP_READ, gen_len, '0);
      push_req(OP_READ, 127, '0);
      // out of bounds insert and remove
      push_req(OP_INSERT, 127, 32'sh0f0f_0f0f);
      push_req(OP_INSERT, gen_len + 1, 32'sh0f0f_0f0f);
      push_req(OP_REMOVE, gen_len, '0);
      push_req(OP_REMOVE, 127, '0);
      // middle removal, pop-front, pop-back
      push_req(OP_REMOVE, 2, 32'sh2222_2222);
      push_req(OP_REMOVE, 0, '0);
      push_req(OP_REMOVE, gen_len - 1, '0);
      push_req(OP_READ, 0, '0);
      push_req(OP_READ, 1, '0);
      // drain to empty and poke it once more
      push_req(OP_REMOVE, 0, '0);
      push_req(OP_REMOVE, 0, '0);
      push_req(OP_READ, 0, '0);
      push_req(OP_APPEND, 0, 32'sh0000_0001);

      // random traffic that repeatedly fills and drains the list
      phase      = PH_GROW;
      phase_left = 0;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         case (phase)
            PH_GROW: if (gen_len >= DEPTH) begin
               phase      = PH_AT_FULL;
               phase_left = $urandom_range(6, 12);
            end
            PH_AT_FULL: if (phase_left == 0) phase = PH_SHRINK;
            PH_SHRINK: if (gen_len == 0) begin
               phase      = PH_MIXED;
               phase_left = $urandom_range(20, 40);
            end
            default: if (phase_left == 0) phase = PH_GROW;
         endcase
         if (phase_left > 0) phase_left--;
         op = pick_op(phase);
         push_req(op, pick_position(op), pick_value());
      end
      total_items = req_q.size();

      // synchronous reset, released away from the active edge
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // wait until every request is in and every response is back
      while (!(accepted_cnt == total_items && expected_rsp_q.size() == 0))
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_cnt == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

   // request driver: a held request stays put until it is taken
   always @(negedge clock) begin : drive_requests
      list_req_type item;
      if (!reset && (!req_valid || req_accepted)) begin
         if (req_gap_left > 0) begin
            req_gap_left--;
            req_valid <= 1'b0;
         end else if (req_q.size() > 0) begin
            item = req_q.pop_front();
            req_valid    <= 1'b1;
            req_op       <= item.op;
            req_position <= item.position;
            req_value    <= item.value;
            // idle after this request once it has been taken
            req_gap_left = pick_gap();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response stall: random bursts plus the long hold-off
   always @(negedge clock) begin : drive_stall
      logic stall_now;
      if (rsp_gap_left > 0) begin
         rsp_gap_left--;
         stall_now = 1'b1;
      end else begin
         stall_now = 1'b0;
         if ($urandom_range(0, 3) == 0) rsp_gap_left = pick_gap();
      end
      rsp_stall <= hold_off || stall_now;
   end

   // long hold-off on the response side, the sender keeps offering meanwhile
   initial begin : long_hold
      @(negedge reset);
      for (int k = 0; k < 2; k++) begin
         repeat (300 + 700 * k) @(posedge clock);
         hold_off = 1'b1;
         repeat (200) @(posedge clock);
         hold_off = 1'b0;
      end
   end

   // monitor: check the response first, then predict the request taken at this edge
   always @(posedge clock) begin : watch_ports
      list_rsp_type got;
      list_rsp_type want;
      list_req_type taken;
      if (reset) begin
         req_accepted <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_status, rsp_count, rsp_read_value};
            if (expected_rsp_q.size() == 0) begin
               $display("%0t: unexpected response: status %0d count %0d read_value %0d",
                        $time, got.status, got.count, got.read_value);
               fail_cnt++;
            end else begin
               want = expected_rsp_q.pop_front();
               if (got.status !== want.status) begin
                  $display("%0t: status mismatch: expected %0d, actual %0d",
                           $time, want.status, got.status);
                  fail_cnt++;
               end
               if (got.count !== want.count) begin
                  $display("%0t: count mismatch: expected %0d, actual %0d",
                           $time, want.count, got.count);
                  fail_cnt++;
               end
               if (got.read_value !== want.read_value) begin
                  $display("%0t: read_value mismatch: expected %0d, actual %0d",
                           $time, want.read_value, got.read_value);
                  fail_cnt++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            taken = {req_op, req_position, req_value};
            expected_rsp_q.push_back(apply_list_op(taken));
            accepted_cnt++;
         end
         req_accepted <= req_valid && !req_stall;
      end
   end

   // watchdog on the cycle counter
   initial begin : watchdog
      while (cycle_cnt < CYCLE_LIMIT) @(posedge clock);
      $display("TEST FAILED");
      $finish;
   end

endmodule

// ----- indexed_shift_list.f -----
design/isl_pkg.sv
design/isl_cell.sv
design/indexed_shift_list.sv
sim/indexed_shift_list_tb.sv
